[design/assert_macros.svh]
// -----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on i_clk, off during reset.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[design/fcf_pkg.sv]
// -----------------------------------------------------------------------------
// fcf_pkg
// Constants, types and codes shared by the FIR convolution filter files.
// -----------------------------------------------------------------------------
`default_nettype none

package fcf_pkg;

    localparam int MAX_TAPS    = 256;
    localparam int SAMPLE_BITS = 16;
    localparam int COEF_BITS   = 16;
    localparam int FRAC_BITS   = 14;
    localparam int MODE_BITS   = 2;
    localparam int INDEX_BITS  = 8;
    localparam int LEN_BITS    = 9;
    localparam int ADDR_W      = $clog2(MAX_TAPS);
    localparam int PROD_W      = SAMPLE_BITS + COEF_BITS;
    localparam int ACC_W       = PROD_W + ADDR_W;

    localparam logic signed [COEF_BITS-1:0] UNIT_TAP   = COEF_BITS'(1 << FRAC_BITS);
    localparam logic signed [ACC_W:0]       ROUND_HALF = (ACC_W+1)'(1 << (FRAC_BITS - 1));
    localparam logic signed [ACC_W:0]       SAT_HI     = (ACC_W+1)'(2**(SAMPLE_BITS-1) - 1);
    localparam logic signed [ACC_W:0]       SAT_LO     = ~SAT_HI;
    localparam logic [LEN_BITS-1:0]         LEN_RESET  = LEN_BITS'(1);
    localparam logic [LEN_BITS-1:0]         LEN_MAX    = LEN_BITS'(MAX_TAPS);

    typedef enum logic [MODE_BITS-1:0] {
        MODE_SAMPLE = 2'd0,
        MODE_TAP    = 2'd1,
        MODE_CLEAR  = 2'd2,
        MODE_NONE   = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MAC,
        S_ROUND,
        S_HOLD
    } t_state;

    // Controls from the sequencer to the datapath.
    typedef struct packed {
        logic clr;
        logic data_vld;
        logic round;
    } t_mac_ctrl;

endpackage

`default_nettype wire

[design/fcf_if.sv]
// -----------------------------------------------------------------------------
// fcf_if
// Valid/ready channels for filter input items and result items.
// -----------------------------------------------------------------------------
`default_nettype none

interface fcf_in_if;
    logic                                valid;
    logic                                ready;
    logic [fcf_pkg::MODE_BITS-1:0]       mode;
    logic signed [fcf_pkg::SAMPLE_BITS-1:0] sample_in;
    logic [fcf_pkg::INDEX_BITS-1:0]      tap_index;
    logic signed [fcf_pkg::COEF_BITS-1:0]   coefficient;

    modport source (output valid, output mode, output sample_in, output tap_index,
                    output coefficient, input ready);
    modport sink   (input valid, input mode, input sample_in, input tap_index,
                    input coefficient, output ready);
endinterface

interface fcf_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [fcf_pkg::SAMPLE_BITS-1:0] sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink   (input valid, input sample_out, output ready);
endinterface

`default_nettype wire

[design/fcf_ram.sv]
// -----------------------------------------------------------------------------
// fcf_ram
// Generic single-write, single-read RAM with registered read data.
// -----------------------------------------------------------------------------
`default_nettype none

module fcf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

[design/fcf_mac.sv]
// -----------------------------------------------------------------------------
// fcf_mac
// Multiply-accumulate datapath with round-half-up and saturation to a sample.
// -----------------------------------------------------------------------------
`default_nettype none

module fcf_mac (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire fcf_pkg::t_mac_ctrl                   i_ctrl,
    input  wire logic signed [fcf_pkg::COEF_BITS-1:0]   i_tap,
    input  wire logic signed [fcf_pkg::SAMPLE_BITS-1:0] i_hist,
    output logic                                      o_prod_vld,
    output logic signed [fcf_pkg::SAMPLE_BITS-1:0]      o_y
);

    logic signed [fcf_pkg::PROD_W-1:0]      r_prod;
    logic                                   r_prod_vld;
    logic signed [fcf_pkg::ACC_W-1:0]       r_acc;
    logic signed [fcf_pkg::SAMPLE_BITS-1:0] r_y;
    logic signed [fcf_pkg::ACC_W:0]         w_sum;
    logic signed [fcf_pkg::ACC_W:0]         w_shr;
    logic signed [fcf_pkg::SAMPLE_BITS-1:0] n_y;

    // Product stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_vld <= 1'b0;
        end else begin
            r_prod_vld <= i_ctrl.data_vld;
        end
        r_prod <= i_tap * i_hist;
    end

    // Accumulate stage
    always_ff @(posedge i_clk) begin
        if (i_ctrl.clr) begin
            r_acc <= '0;
        end else if (r_prod_vld) begin
            r_acc <= r_acc + fcf_pkg::ACC_W'(r_prod);
        end
    end

    // Round half up, then clamp to the sample range
    always_comb begin
        w_sum = fcf_pkg::ACC_W'(r_acc) + fcf_pkg::ROUND_HALF;
        w_shr = w_sum >>> fcf_pkg::FRAC_BITS;
        if (w_shr > fcf_pkg::SAT_HI) begin
            n_y = fcf_pkg::SAT_HI[fcf_pkg::SAMPLE_BITS-1:0];
        end else if (w_shr < fcf_pkg::SAT_LO) begin
            n_y = fcf_pkg::SAT_LO[fcf_pkg::SAMPLE_BITS-1:0];
        end else begin
            n_y = w_shr[fcf_pkg::SAMPLE_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.round) begin
            r_y <= n_y;
        end
    end

    assign o_prod_vld = r_prod_vld;
    assign o_y        = r_y;

endmodule

`default_nettype wire

[design/fir_convolution_filter_core.sv]
// -----------------------------------------------------------------------------
// fir_convolution_filter_core
// Direct-form FIR convolution of a 16-bit audio stream with a loaded response.
// Input channel i_item carries a mode: sample (one result), tap write, history
// clear or none (no result). Output channel o_result carries the filtered
// sample, Q2.14 taps applied, rounded half up and saturated to 16 bits.
// From acceptance to the result register a sample passes through one
// multiply-accumulate per tap, with one RAM read of history and taps per
// cycle, then the product, accumulate, drain, round and load stages. Tap
// writes and history clears leave the sequencer idle. One item is worked
// on at a time; i_item.ready is high while the sequencer is idle, including
// while a result waits in the output register. A stalled receiver holds
// that result; the next sample then waits before its load stage until the
// register is taken.
// Reset clears the history, loads the unit response (tap zero = 1.0) and sets
// response_length to 1; no clearing pass is needed. i_cfg_we writes
// response_length; the user must write it only while idle, as the block does
// not enforce this. Values above 256 act as 256.
// -----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module fir_convolution_filter_core (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    fcf_in_if.sink                              i_item,
    fcf_out_if.source                           o_result,
    input  wire logic                           i_cfg_we,
    input  wire logic [fcf_pkg::LEN_BITS-1:0]   i_cfg_wdata
);

    fcf_pkg::t_state r_state, n_state;

    logic [fcf_pkg::LEN_BITS-1:0]    r_cfg_len;
    logic [fcf_pkg::LEN_BITS-1:0]    r_len;
    logic [fcf_pkg::LEN_BITS-1:0]    r_issue_k;
    logic [fcf_pkg::LEN_BITS-1:0]    r_fill;
    logic [fcf_pkg::ADDR_W-1:0]      r_ptr;
    logic [fcf_pkg::MAX_TAPS-1:0]    r_tap_vld;
    logic                            r_rd_vld;
    logic                            r_hist_ok;
    logic                            r_tap_ok;
    logic                            r_tap_first;
    logic                            r_out_vld;
    logic signed [fcf_pkg::SAMPLE_BITS-1:0] r_out_data;

    logic                            w_accept;
    logic                            w_sample;
    logic                            w_tapwr;
    logic                            w_clear;
    logic                            w_issue;
    logic                            w_load;
    logic                            w_slot_free;
    logic [fcf_pkg::ADDR_W-1:0]      w_ptr_next;
    logic [fcf_pkg::ADDR_W-1:0]      w_tap_raddr;
    logic [fcf_pkg::ADDR_W-1:0]      w_hist_raddr;
    logic [fcf_pkg::ADDR_W-1:0]      w_tap_waddr;
    logic [fcf_pkg::SAMPLE_BITS-1:0] w_hist_rdata;
    logic [fcf_pkg::COEF_BITS-1:0]   w_tap_rdata;
    logic signed [fcf_pkg::SAMPLE_BITS-1:0] w_hist;
    logic signed [fcf_pkg::COEF_BITS-1:0]   w_tap;
    logic signed [fcf_pkg::SAMPLE_BITS-1:0] w_y;
    logic                            w_prod_vld;
    fcf_pkg::t_mac_ctrl              w_ctrl;

    // Decode the accepted item
    assign i_item.ready = (r_state == fcf_pkg::S_IDLE);
    assign w_accept     = i_item.valid && i_item.ready;
    assign w_sample     = w_accept && (i_item.mode == fcf_pkg::MODE_SAMPLE);
    assign w_tapwr      = w_accept && (i_item.mode == fcf_pkg::MODE_TAP)
                          && ({1'b0, i_item.tap_index} < (fcf_pkg::INDEX_BITS+1)'(fcf_pkg::MAX_TAPS));
    assign w_clear      = w_accept && (i_item.mode == fcf_pkg::MODE_CLEAR);
    assign w_ptr_next   = r_ptr + fcf_pkg::ADDR_W'(1);
    assign w_tap_waddr  = fcf_pkg::ADDR_W'(i_item.tap_index);

    // Tap reads walk forward from tap zero, history reads walk back from newest
    assign w_issue      = (r_state == fcf_pkg::S_MAC) && (r_issue_k != r_len);
    assign w_tap_raddr  = r_issue_k[fcf_pkg::ADDR_W-1:0];
    assign w_hist_raddr = r_ptr - r_issue_k[fcf_pkg::ADDR_W-1:0];

    assign w_slot_free  = !r_out_vld || o_result.ready;
    assign w_load       = (r_state == fcf_pkg::S_HOLD) && w_slot_free;

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_len <= fcf_pkg::LEN_RESET;
        end else if (i_cfg_we) begin
            r_cfg_len <= i_cfg_wdata;
        end
    end

    // Sequencer state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fcf_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and datapath controls
    always_comb begin
        n_state       = r_state;
        w_ctrl.clr    = w_sample;
        w_ctrl.data_vld = r_rd_vld;
        w_ctrl.round  = 1'b0;
        case (r_state)
            fcf_pkg::S_IDLE: begin
                if (w_sample) begin
                    n_state = fcf_pkg::S_MAC;
                end
            end
            fcf_pkg::S_MAC: begin
                if (!w_issue && !r_rd_vld && !w_prod_vld) begin
                    n_state = fcf_pkg::S_ROUND;
                end
            end
            fcf_pkg::S_ROUND: begin
                w_ctrl.round = 1'b1;
                n_state      = fcf_pkg::S_HOLD;
            end
            fcf_pkg::S_HOLD: begin
                if (w_slot_free) begin
                    n_state = fcf_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = fcf_pkg::S_IDLE;
            end
        endcase
    end

    // Pointer, tap count and issue counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr     <= '0;
            r_issue_k <= '0;
            r_len     <= '0;
        end else begin
            if (w_sample) begin
                r_ptr     <= w_ptr_next;
                r_issue_k <= '0;
                r_len     <= (r_cfg_len > fcf_pkg::LEN_MAX) ? fcf_pkg::LEN_MAX : r_cfg_len;
            end else if (w_clear) begin
                r_ptr <= '0;
            end else if (w_issue) begin
                r_issue_k <= r_issue_k + fcf_pkg::LEN_BITS'(1);
            end
        end
    end

    // History fill count: entries further back than this read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (w_clear) begin
            r_fill <= '0;
        end else if (w_sample && (r_fill != fcf_pkg::LEN_MAX)) begin
            r_fill <= r_fill + fcf_pkg::LEN_BITS'(1);
        end
    end

    // Valid bits: a tap never written reads as its reset value
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_vld  <= '0;
        end else begin
            if (w_tapwr) begin
                r_tap_vld[w_tap_waddr] <= 1'b1;
            end
        end
    end

    // Read stage tracking, aligned with the registered RAM outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= w_issue;
        end
        r_hist_ok   <= (r_issue_k < r_fill);
        r_tap_ok    <= r_tap_vld[w_tap_raddr];
        r_tap_first <= (w_tap_raddr == '0);
    end

    fcf_ram #(
        .WIDTH (fcf_pkg::SAMPLE_BITS),
        .DEPTH (fcf_pkg::MAX_TAPS)
    ) u_hist_ram (
        .i_clk   (i_clk),
        .i_we    (w_sample),
        .i_waddr (w_ptr_next),
        .i_wdata (i_item.sample_in),
        .i_raddr (w_hist_raddr),
        .o_rdata (w_hist_rdata)
    );

    fcf_ram #(
        .WIDTH (fcf_pkg::COEF_BITS),
        .DEPTH (fcf_pkg::MAX_TAPS)
    ) u_tap_ram (
        .i_clk   (i_clk),
        .i_we    (w_tapwr),
        .i_waddr (w_tap_waddr),
        .i_wdata (i_item.coefficient),
        .i_raddr (w_tap_raddr),
        .o_rdata (w_tap_rdata)
    );

    // Substitute reset values for entries not yet written
    always_comb begin
        w_hist = r_hist_ok ? $signed(w_hist_rdata) : '0;
        if (r_tap_ok) begin
            w_tap = $signed(w_tap_rdata);
        end else if (r_tap_first) begin
            w_tap = fcf_pkg::UNIT_TAP;
        end else begin
            w_tap = '0;
        end
    end

    fcf_mac u_mac (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (w_ctrl),
        .i_tap      (w_tap),
        .i_hist     (w_hist),
        .o_prod_vld (w_prod_vld),
        .o_y        (w_y)
    );

    // Output register: load when free or being taken, drop on take
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_load) begin
            r_out_vld <= 1'b1;
        end else if (o_result.ready) begin
            r_out_vld <= 1'b0;
        end
        if (w_load) begin
            r_out_data <= w_y;
        end
    end

    assign o_result.valid      = r_out_vld;
    assign o_result.sample_out = r_out_data;

    // Checks
    `ASSERT_IMPL(a_idle_pipe_empty, i_item.ready, !r_rd_vld && !w_prod_vld)
    `ASSERT_IMPL(a_issue_bound, r_state == fcf_pkg::S_MAC, r_issue_k <= r_len)
    `ASSERT_NEXT(a_sample_starts, w_sample, r_state == fcf_pkg::S_MAC && r_issue_k == '0)
    `ASSERT_IMPL(a_load_from_hold, $rose(r_out_vld), $past(r_state == fcf_pkg::S_HOLD))

endmodule

`default_nettype wire
